// ===== design/hmbd_pkg.sv =====
// Shared types and constants for the handheld memory bus decoder.
// Holds the bus transfer structs, the address region decode and the I/O power-up table.
// Depends on nothing; the decoder refers to it by scoped names.
`default_nettype none

package hmbd_pkg;

	typedef enum logic [0:0] {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        vram_locked;
		logic        oam_locked;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       to_cartridge;
	} rsp_t;

	typedef enum logic [3:0] {
		REG_CART    = 4'd0,
		REG_VRAM    = 4'd1,
		REG_WRAM_LO = 4'd2,
		REG_WRAM_HI = 4'd3,
		REG_OAM     = 4'd4,
		REG_IO      = 4'd5,
		REG_HRAM    = 4'd6,
		REG_IE      = 4'd7,
		REG_NONE    = 4'd8
	} region_t;

	localparam int VRAM_DEPTH = 8192;
	localparam int WRAM_DEPTH = 4096;
	localparam int OAM_DEPTH  = 160;
	localparam int IO_DEPTH   = 128;
	localparam int HRAM_DEPTH = 127;

	localparam logic [6:0] IO_STAT = 7'h41;
	localparam logic [6:0] IO_LY   = 7'h44;
	localparam logic [6:0] IO_LYC  = 7'h45;
	localparam int STAT_COINCIDENCE_BIT = 2;

	localparam logic [7:0] LOCKED_READ = 8'hFF;

	// Map a bus address onto the region that serves it.
	function automatic region_t decode(input logic [15:0] a);
		region_t r;
		r = REG_NONE;
		if (!a[15]) begin
			r = REG_CART;
		end else if (a[15:13] == 3'b100) begin
			r = REG_VRAM;
		end else if (a[15:13] == 3'b101) begin
			r = REG_CART;
		end else if (a[15:12] == 4'hC || a[15:12] == 4'hE) begin
			r = REG_WRAM_LO;
		end else if (a[15:12] == 4'hD) begin
			r = REG_WRAM_HI;
		end else if (a[15:12] == 4'hF && a[11:9] != 3'b111) begin
			r = REG_WRAM_HI;
		end else if (a[15:8] == 8'hFE) begin
			r = (a[7:0] < 8'hA0) ? REG_OAM : REG_NONE;
		end else if (a == 16'hFFFF) begin
			r = REG_IE;
		end else begin
			r = a[7] ? REG_HRAM : REG_IO;
		end
		return r;
	endfunction

	// Power-up contents of the I/O register file.
	function automatic logic [7:0] io_power_up(input logic [6:0] idx);
		logic [7:0] v;
		case (idx)
			7'h00: v = 8'hCF;
			7'h02: v = 8'h7E;
			7'h04: v = 8'hAB;
			7'h07: v = 8'hF8;
			7'h0F: v = 8'hE1;
			7'h10: v = 8'h80;
			7'h11: v = 8'hBF;
			7'h12: v = 8'hF3;
			7'h13: v = 8'hFF;
			7'h14: v = 8'hBF;
			7'h16: v = 8'h3F;
			7'h18: v = 8'hFF;
			7'h19: v = 8'hBF;
			7'h1A: v = 8'h7F;
			7'h1B: v = 8'hFF;
			7'h1C: v = 8'h9F;
			7'h1D: v = 8'hFF;
			7'h1E: v = 8'hBF;
			7'h20: v = 8'hFF;
			7'h23: v = 8'hBF;
			7'h24: v = 8'h77;
			7'h25: v = 8'hF3;
			7'h26: v = 8'hF1;
			7'h40: v = 8'h91;
			7'h41: v = 8'h85;
			7'h46: v = 8'hFF;
			7'h47: v = 8'hFC;
			7'h48: v = 8'hFF;
			7'h49: v = 8'hFF;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== design/hmbd_ram.sv =====
// Generic single-port RAM with a registered, enabled read.
// Used for every byte store of the decoder; depends on nothing.
`default_nettype none

module hmbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/handheld_memory_bus_decoder.sv =====
// Handheld memory bus decoder: one CPU byte access per transfer, decoded against the memory map.
// A result passes through stage one and the result register; throughput one per cycle while rsp_stall stays low.
// The RAM read port (registered read) sets the first stage, the result register the second.
// Reset clears handshake state, I/O valid bits and interrupt enable; STAT and LYC get power-up.
// Byte stores come up undefined; I/O registers never written read their power-up values.
// Depends on hmbd_pkg and hmbd_ram.
`default_nettype none

module handheld_memory_bus_decoder (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire hmbd_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output hmbd_pkg::rsp_t     rsp
);

	// Request side. A transfer happens when valid is high and we are not stalling.
	// The stores are written and read at the transfer edge itself, so every later
	// request sees the effect of every earlier write.
	logic              req_accept;
	hmbd_pkg::region_t req_region;
	logic              req_write;

	assign req_accept = req_valid && !req_stall;
	assign req_region = hmbd_pkg::decode(req.address);
	assign req_write  = req_accept && (req.cmd == hmbd_pkg::CMD_WRITE);

	// Stage one holds the decoded access while the RAM read data settles.
	logic              valid_s1;
	logic              cmd_s1;
	hmbd_pkg::region_t region_s1;
	logic [6:0]        io_idx_s1;
	logic              vlock_s1;
	logic              olock_s1;

	// Result register.
	logic           rsp_valid_q;
	hmbd_pkg::rsp_t rsp_q;
	logic           advance;

	// The result register frees up when it is empty or its contents are taken.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	// Byte stores. All of them read on every request transfer; the result
	// register only picks the one that the region decode names.
	logic [7:0] vram_rd, wlo_rd, whi_rd, oam_rd, io_rd, hram_rd;

	hmbd_ram #(.WIDTH(8), .DEPTH(hmbd_pkg::VRAM_DEPTH)) u_vram (
		.clk   (clk),
		.re    (req_accept),
		.we    (req_write && req_region == hmbd_pkg::REG_VRAM),
		.addr  (req.address[$clog2(hmbd_pkg::VRAM_DEPTH)-1:0]),
		.wdata (req.write_data),
		.rdata (vram_rd)
	);

	// Echo RAM at E000-EFFF lands here as well, since it shares the low twelve address bits.
	hmbd_ram #(.WIDTH(8), .DEPTH(hmbd_pkg::WRAM_DEPTH)) u_wram_lo (
		.clk   (clk),
		.re    (req_accept),
		.we    (req_write && req_region == hmbd_pkg::REG_WRAM_LO),
		.addr  (req.address[$clog2(hmbd_pkg::WRAM_DEPTH)-1:0]),
		.wdata (req.write_data),
		.rdata (wlo_rd)
	);

	hmbd_ram #(.WIDTH(8), .DEPTH(hmbd_pkg::WRAM_DEPTH)) u_wram_hi (
		.clk   (clk),
		.re    (req_accept),
		.we    (req_write && req_region == hmbd_pkg::REG_WRAM_HI),
		.addr  (req.address[$clog2(hmbd_pkg::WRAM_DEPTH)-1:0]),
		.wdata (req.write_data),
		.rdata (whi_rd)
	);

	hmbd_ram #(.WIDTH(8), .DEPTH(hmbd_pkg::OAM_DEPTH)) u_oam (
		.clk   (clk),
		.re    (req_accept),
		.we    (req_write && req_region == hmbd_pkg::REG_OAM),
		.addr  (req.address[$clog2(hmbd_pkg::OAM_DEPTH)-1:0]),
		.wdata (req.write_data),
		.rdata (oam_rd)
	);

	// The I/O file is a RAM too. Its valid bits tell a written entry from one
	// that still holds its power-up value.
	hmbd_ram #(.WIDTH(8), .DEPTH(hmbd_pkg::IO_DEPTH)) u_io (
		.clk   (clk),
		.re    (req_accept),
		.we    (req_write && req_region == hmbd_pkg::REG_IO),
		.addr  (req.address[$clog2(hmbd_pkg::IO_DEPTH)-1:0]),
		.wdata (req.write_data),
		.rdata (io_rd)
	);

	hmbd_ram #(.WIDTH(8), .DEPTH(hmbd_pkg::HRAM_DEPTH)) u_hram (
		.clk   (clk),
		.re    (req_accept),
		.we    (req_write && req_region == hmbd_pkg::REG_HRAM),
		.addr  (req.address[$clog2(hmbd_pkg::HRAM_DEPTH)-1:0]),
		.wdata (req.write_data),
		.rdata (hram_rd)
	);

	// STAT and LYC live in flip-flops because a write to LY must read LYC and
	// update STAT in the same cycle. Reads of those two addresses use these.
	logic [hmbd_pkg::IO_DEPTH-1:0] io_valid_q;
	logic [7:0]                    stat_q;
	logic [7:0]                    lyc_q;
	logic [7:0]                    ie_q;
	logic                          io_write;
	logic [6:0]                    req_io_idx;

	assign req_io_idx = req.address[6:0];
	assign io_write   = req_write && req_region == hmbd_pkg::REG_IO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_valid_q <= '0;
			stat_q     <= hmbd_pkg::io_power_up(hmbd_pkg::IO_STAT);
			lyc_q      <= hmbd_pkg::io_power_up(hmbd_pkg::IO_LYC);
			ie_q       <= 8'h00;
		end else begin
			if (io_write) begin
				io_valid_q[req_io_idx] <= 1'b1;
				if (req_io_idx == hmbd_pkg::IO_STAT) begin
					stat_q <= req.write_data;
				end
				if (req_io_idx == hmbd_pkg::IO_LYC) begin
					lyc_q <= req.write_data;
				end
				// LY coincidence: set or clear the STAT flag against the current LYC.
				if (req_io_idx == hmbd_pkg::IO_LY) begin
					stat_q[hmbd_pkg::STAT_COINCIDENCE_BIT] <= (req.write_data == lyc_q);
				end
			end
			if (req_write && req_region == hmbd_pkg::REG_IE) begin
				ie_q <= req.write_data;
			end
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// Stage one payload; it changes only together with a request transfer.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			cmd_s1    <= req.cmd;
			region_s1 <= req_region;
			io_idx_s1 <= req_io_idx;
			vlock_s1  <= req.vram_locked;
			olock_s1  <= req.oam_locked;
		end
	end

	// Read data selection. STAT, LYC and the valid bits are looked at here,
	// before any later request can write them: a later transfer only happens at
	// the edge that moves this item into the result register.
	logic [7:0]     io_value;
	hmbd_pkg::rsp_t rsp_d;

	always_comb begin
		if (io_idx_s1 == hmbd_pkg::IO_STAT) begin
			io_value = stat_q;
		end else if (io_idx_s1 == hmbd_pkg::IO_LYC) begin
			io_value = lyc_q;
		end else if (io_valid_q[io_idx_s1]) begin
			io_value = io_rd;
		end else begin
			io_value = hmbd_pkg::io_power_up(io_idx_s1);
		end
	end

	always_comb begin
		rsp_d.to_cartridge = 1'b0;
		rsp_d.read_data    = 8'h00;
		case (region_s1)
			hmbd_pkg::REG_CART:    rsp_d.to_cartridge = 1'b1;
			hmbd_pkg::REG_VRAM:    rsp_d.read_data = vlock_s1 ? hmbd_pkg::LOCKED_READ : vram_rd;
			hmbd_pkg::REG_WRAM_LO: rsp_d.read_data = wlo_rd;
			hmbd_pkg::REG_WRAM_HI: rsp_d.read_data = whi_rd;
			hmbd_pkg::REG_OAM:     rsp_d.read_data = olock_s1 ? hmbd_pkg::LOCKED_READ : oam_rd;
			hmbd_pkg::REG_IO:      rsp_d.read_data = io_value;
			hmbd_pkg::REG_HRAM:    rsp_d.read_data = hram_rd;
			hmbd_pkg::REG_IE:      rsp_d.read_data = ie_q;
			default:               rsp_d.read_data = 8'h00;
		endcase
		// Writes never return data.
		if (cmd_s1 == hmbd_pkg::CMD_WRITE) begin
			rsp_d.read_data = 8'h00;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A cartridge-forwarded access never carries read data.
	a_cart_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.to_cartridge |-> rsp_q.read_data == 8'h00)
		else $error("cartridge access returned data");

	// An empty first stage never holds off the requester.
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("stall raised with empty stage one");

	// Every request transfer occupies stage one in the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> valid_s1)
		else $error("accepted request lost");

	// A write to LY that matches LYC sets the STAT coincidence flag.
	a_ly_match: assert property (@(posedge clk) disable iff (!arst_n)
		io_write && req_io_idx == hmbd_pkg::IO_LY && req.write_data == lyc_q
		|=> stat_q[hmbd_pkg::STAT_COINCIDENCE_BIT])
		else $error("LY coincidence flag not set");

endmodule

`default_nettype wire

// ===== dv/tb_handheld_memory_bus_decoder.sv =====
// Self-checking testbench for the handheld memory bus decoder.
// Drives bus access transfers, predicts every response from its own memory map image, and
// compares field by field. Depends on hmbd_pkg and the handheld_memory_bus_decoder RTL.
`default_nettype none

module tb_handheld_memory_bus_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import hmbd_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned RANDOM_ACCESSES = 1400;
	localparam int unsigned SETTLE_CYCLES = 12;

	localparam logic [15:0] ADDR_STAT = {8'hFF, 1'b0, IO_STAT};
	localparam logic [15:0] ADDR_LY   = {8'hFF, 1'b0, IO_LY};
	localparam logic [15:0] ADDR_LYC  = {8'hFF, 1'b0, IO_LYC};
	localparam logic [15:0] ADDR_IE   = 16'hFFFF;

	// Power-up contents of the first 0x50 I/O registers; the rest come up zero.
	localparam logic [7:0] IO_POWER_UP [0:79] = '{
		8'hCF, 8'h00, 8'h7E, 8'h00, 8'hAB, 8'h00, 8'h00, 8'hF8,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE1,
		8'h80, 8'hBF, 8'hF3, 8'hFF, 8'hBF, 8'h00, 8'h3F, 8'h00,
		8'hFF, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'h00,
		8'hFF, 8'h00, 8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h91, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFC,
		8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// The scoreboard keeps a flat image of the address space. Echo RAM is folded onto
	// work RAM, so both aliases of a byte share one entry. It also remembers which RAM
	// bytes have been written, since reading any other RAM byte is not allowed.
	class access_scoreboard;
		logic [7:0]  mem_image [0:65535];
		bit          filled [0:65535];
		logic [15:0] filled_addrs [$];
		rsp_t        awaited [$];
		int unsigned errors;
		int unsigned reads;
		int unsigned writes;
		int unsigned cart_hits;
		int unsigned locked_reads;
		int unsigned ly_matches;

		function new();
			for (int i = 0; i < 65536; i++) begin
				mem_image[i] = 8'h00;
				filled[i] = 1'b0;
			end
			for (int i = 0; i < 80; i++) begin
				mem_image[16'hFF00 + i] = IO_POWER_UP[i];
			end
		endfunction

		function region_t region_of(logic [15:0] a);
			if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) return REG_CART;
			if (a <= 16'h9FFF) return REG_VRAM;
			if (a <= 16'hCFFF) return REG_WRAM_LO;
			if (a <= 16'hDFFF) return REG_WRAM_HI;
			if (a <= 16'hEFFF) return REG_WRAM_LO;
			if (a <= 16'hFDFF) return REG_WRAM_HI;
			if (a <= 16'hFE9F) return REG_OAM;
			if (a <= 16'hFEFF) return REG_NONE;
			if (a <= 16'hFF7F) return REG_IO;
			if (a <= 16'hFFFE) return REG_HRAM;
			return REG_IE;
		endfunction

		function logic [15:0] fold_echo(logic [15:0] a);
			return (a >= 16'hE000 && a <= 16'hFDFF) ? a - 16'h2000 : a;
		endfunction

		function void note_request(req_t r);
			rsp_t        want;
			region_t     g;
			logic [15:0] c;
			want = '0;
			g = region_of(r.address);
			c = fold_echo(r.address);
			if (g == REG_CART) begin
				want.to_cartridge = 1'b1;
				cart_hits++;
			end else if (r.cmd == CMD_WRITE) begin
				writes++;
				if (g != REG_NONE) mem_image[c] = r.write_data;
				if (g != REG_NONE && g != REG_IO && g != REG_IE && !filled[c]) begin
					filled[c] = 1'b1;
					filled_addrs.push_back(c);
				end
				// Writing LY compares it against LYC and updates the STAT coincidence flag.
				if (c == ADDR_LY) begin
					if (r.write_data == mem_image[ADDR_LYC]) begin
						mem_image[ADDR_STAT][STAT_COINCIDENCE_BIT] = 1'b1;
						ly_matches++;
					end else begin
						mem_image[ADDR_STAT][STAT_COINCIDENCE_BIT] = 1'b0;
					end
				end
			end else begin
				reads++;
				case (g)
					REG_VRAM: begin
						want.read_data = r.vram_locked ? LOCKED_READ : mem_image[c];
						if (r.vram_locked) locked_reads++;
					end
					REG_OAM: begin
						want.read_data = r.oam_locked ? LOCKED_READ : mem_image[c];
						if (r.oam_locked) locked_reads++;
					end
					REG_NONE: want.read_data = 8'h00;
					default: want.read_data = mem_image[c];
				endcase
			end
			awaited.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$error("Response transfer with nothing awaited: read_data %h to_cartridge %b",
					got.read_data, got.to_cartridge);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %h, actual %h", want.read_data, got.read_data);
				errors++;
			end
			if (got.to_cartridge !== want.to_cartridge) begin
				$error("to_cartridge: expected %b, actual %b", want.to_cartridge,
					got.to_cartridge);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	access_scoreboard sb;
	int unsigned req_max_gap = 5;
	int unsigned rsp_max_stall = 5;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;

	handheld_memory_bus_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run is ended here if it hangs, for example when a response never arrives.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// The response side stalls for a freshly drawn number of cycles after each transfer.
	// The count keeps running between responses, so stalls land on every pipeline phase.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Responses are sampled at the rising edge, where the values seen are those from
	// before the edge, so the comparison never races the RTL's own updates.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_response(rsp);
			stall_left = $urandom_range(0, rsp_max_stall);
		end
	end

	function automatic req_t make_access(logic cmd, logic [15:0] a, logic [7:0] d,
		logic vl, logic ol);
		req_t r;
		r.cmd = cmd;
		r.address = a;
		r.write_data = d;
		r.vram_locked = vl;
		r.oam_locked = ol;
		return r;
	endfunction

	// Draws one random access. RAM reads only target bytes written earlier, possibly
	// through the echo alias. The LY and LYC writes use tiny values so that the
	// coincidence flag is both set and cleared often.
	function automatic req_t random_access();
		req_t        r;
		int unsigned pick;
		logic [15:0] c;
		r.cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
		r.address = 16'($urandom_range(0, 65535));
		r.write_data = 8'($urandom_range(0, 255));
		r.vram_locked = 1'($urandom_range(0, 1));
		r.oam_locked = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			r.address = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h7FFF))
				: 16'($urandom_range(16'hA000, 16'hBFFF));
		end else if (pick < 32) begin
			r.cmd = CMD_WRITE;
			case ($urandom_range(0, 3))
				0: r.address = 16'($urandom_range(16'h8000, 16'h9FFF));
				1: r.address = 16'($urandom_range(16'hC000, 16'hFDFF));
				2: r.address = 16'($urandom_range(16'hFE00, 16'hFE9F));
				default: r.address = 16'($urandom_range(16'hFF80, 16'hFFFE));
			endcase
		end else if (pick < 57 && sb.filled_addrs.size() > 0) begin
			r.cmd = CMD_READ;
			c = sb.filled_addrs[$urandom_range(0, sb.filled_addrs.size() - 1)];
			if (c >= 16'hC000 && c <= 16'hDDFF && $urandom_range(0, 1))
				r.address = c + 16'h2000;
			else
				r.address = c;
		end else if (pick < 72) begin
			r.address = 16'($urandom_range(16'hFF00, 16'hFF7F));
		end else if (pick < 82) begin
			case ($urandom_range(0, 2))
				0: r = make_access(CMD_WRITE, ADDR_LYC, 8'($urandom_range(0, 3)),
					r.vram_locked, r.oam_locked);
				1: r = make_access(CMD_WRITE, ADDR_LY, 8'($urandom_range(0, 3)),
					r.vram_locked, r.oam_locked);
				default: r.address = ADDR_STAT;
			endcase
			if (r.address == ADDR_STAT) r.cmd = CMD_READ;
		end else if (pick < 88) begin
			r.address = ADDR_IE;
		end else if (pick < 94) begin
			r.address = 16'($urandom_range(16'hFEA0, 16'hFEFF));
		end else begin
			// Any address may be written, which also toggles every address bit.
			r.cmd = CMD_WRITE;
		end
		return r;
	endfunction

	// Offers one request transfer after a random gap and returns at the falling edge
	// that follows its acceptance. Valid stays high across back-to-back transfers.
	task automatic issue_access(input req_t r);
		int unsigned idle;
		idle = $urandom_range(0, req_max_gap);
		if (idle > 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		@(negedge clk);
	endtask

	// Holds off new requests until every awaited response transfer has been checked.
	task automatic wait_for_responses();
		req_valid <= 1'b0;
		do @(negedge clk); while (sb.awaited.size() != 0);
	endtask

	initial begin
		req_t directed [$];
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed accesses: cartridge ranges, power-up reads, every local region, some at
		// their edges, both locks, echo aliasing, the unusable gap and the LY compare.
		directed.push_back(make_access(CMD_READ,  16'h0000, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, 16'h7FFF, 8'hFF, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  16'hBFFF, 8'h00, 1'b1, 1'b1));
		directed.push_back(make_access(CMD_READ,  16'hFF00, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  ADDR_STAT, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  ADDR_IE, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, 16'h8000, 8'hAA, 1'b1, 1'b0));
		directed.push_back(make_access(CMD_READ,  16'h8000, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  16'h8000, 8'h00, 1'b1, 1'b0));
		directed.push_back(make_access(CMD_WRITE, 16'hC000, 8'h11, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  16'hE000, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, 16'hFDFF, 8'h22, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  16'hDDFF, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, 16'hFE9F, 8'h44, 1'b0, 1'b1));
		directed.push_back(make_access(CMD_READ,  16'hFE9F, 8'h00, 1'b0, 1'b1));
		directed.push_back(make_access(CMD_READ,  16'hFE9F, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, 16'hFEA0, 8'h77, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  16'hFEFF, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, 16'hFFFE, 8'h66, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  16'hFFFE, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, ADDR_IE, 8'h1F, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  ADDR_IE, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, ADDR_LYC, 8'h90, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, ADDR_LY, 8'h90, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  ADDR_STAT, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_WRITE, ADDR_LY, 8'h00, 1'b0, 1'b0));
		directed.push_back(make_access(CMD_READ,  ADDR_STAT, 8'h00, 1'b0, 1'b0));
		foreach (directed[i]) issue_access(directed[i]);
		wait_for_responses();

		// Random accesses. Every 64 transfers the idling pattern is drawn anew, so there are
		// stretches where one side, both sides or neither side holds back.
		for (int unsigned n = 0; n < RANDOM_ACCESSES; n++) begin
			if (n % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: begin req_max_gap = 5; rsp_max_stall = 5; end
					1: begin req_max_gap = 0; rsp_max_stall = 0; end
					2: begin req_max_gap = 5; rsp_max_stall = 0; end
					default: begin req_max_gap = 0; rsp_max_stall = 5; end
				endcase
			end
			if (n == RANDOM_ACCESSES / 2) wait_for_responses();
			issue_access(random_access());
		end
		wait_for_responses();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d reads, %0d local writes and %0d cartridge transfers in %0d cycles.",
			sb.reads, sb.writes, sb.cart_hits, cycle_count);
		$display("Locked reads: %0d; LY writes matching LYC: %0d; RAM bytes in use: %0d.",
			sb.locked_reads, sb.ly_matches, sb.filled_addrs.size());
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
